[rtl/core/asft_pkg.sv]
// Shared constants, types and the saturation helper of the anchor spring force block.
package asft_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Stream and configuration port widths.
    localparam int S_DATA_W   = 272;
    localparam int M_DATA_W   = 288;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SPRING = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REST   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CEN_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CEN_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CEN_Z  = 3'd4;

    // Reset values in whole units, scaled by the fraction width at the top level.
    localparam int SPRING_RST_INT = 100;
    localparam int REST_RST_INT   = 1;

    // Iterative units: two result bits are settled in each pipeline stage.
    localparam int STEPS_PER_STAGE = 2;
    localparam int SQ_STEPS   = 32;
    localparam int SQ_STAGES  = (SQ_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int DIV_STEPS  = 31;
    localparam int DIV_STAGES = (DIV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    // Per-word data that rides alongside the arithmetic units.
    typedef struct packed {
        logic [2:0][32:0] dr;
        logic [2:0][33:0] arm_bond;
        logic [2:0][32:0] arm_body;
        logic             shr;
        logic             zero;
    } asft_side_t;

    // Clamp a wide signed value to the signed 32 bit range.
    function automatic logic [31:0] sat32(input logic signed [66:0] v);
        logic [31:0] r;
        if (v[66:31] == '0 || v[66:31] == '1) begin
            r = v[31:0];
        end else if (v[66]) begin
            r = 32'h8000_0000;
        end else begin
            r = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

[rtl/core/anchor_spring_force_torque.sv]
// Top level of the anchor spring force and torque pipeline.
//
//  channel  | ports                          | word
//  ---------+--------------------------------+-------------------------------------
//  input    | s_tvalid s_tready s_tdata      | anchor, tail, direction, bond length
//  result   | m_tvalid m_tready m_tdata      | force, bond torque, body torque
//  config   | cfg_wr_en cfg_index cfg_wdata  | stiffness, rest length, body center
//
// One word enters per cycle while no result is held at the output; latency is set mostly
// by the 16 stage square root and the 16 stage divider that normalizes the separation vector.
// Reset is synchronous and active low; it clears the valid bits and loads the config registers.
// A stall on the result side freezes every stage at once; s_tready follows it.
module anchor_spring_force_torque #(
    parameter int FRAC_BITS = asft_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // anchor_x, anchor_y, anchor_z, tail_x, tail_y, tail_z, dir_x, dir_y, dir_z,
    // bond_length, one zero pad bit
    input  logic [asft_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // force_x, force_y, force_z, bond_torque_x, bond_torque_y, bond_torque_z,
    // body_torque_x, body_torque_y, body_torque_z
    output logic [asft_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [asft_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [asft_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import asft_pkg::*;

    localparam logic [30:0] K_RST  = 31'(SPRING_RST_INT << FRAC_BITS);
    localparam logic [30:0] R0_RST = 31'(REST_RST_INT << FRAC_BITS);

    // Valid bit positions along the pipeline.
    localparam int V_T3  = 2;
    localparam int V_T4  = V_T3 + SQ_STAGES + 1;
    localparam int V_T5  = V_T4 + DIV_STAGES + 1;
    localparam int V_T9  = V_T5 + 4;
    localparam int LAT   = V_T5 + 5 + 3 + 1;

    logic en;

    logic        [30:0] k_reg;
    logic        [30:0] r0_reg;
    logic signed [31:0] cen_reg [3];

    logic [LAT-1:0] vld_reg;

    logic signed [31:0] anc  [3];
    logic signed [31:0] tail [3];
    logic signed [15:0] dir_in [3];
    logic        [30:0] bond_in;

    logic signed [32:0] dr1_reg   [3];
    logic signed [32:0] bd1_reg   [3];
    logic signed [15:0] dir1_reg  [3];
    logic        [30:0] bond1_reg;

    logic        [32:0] mag1 [3];
    logic        [31:0] d1   [3];
    logic               shr1;

    logic        [63:0] sq2_reg [3];
    logic signed [47:0] po2_reg [3];
    asft_side_t         side2_reg;
    asft_side_t         side2_next;

    logic        [63:0] sum3_reg;
    asft_side_t         side3_reg;
    asft_side_t         side3_next;

    logic        [31:0] root_sq;
    asft_side_t         side_sq_reg [SQ_STAGES];
    logic        [32:0] m_w;
    logic        [32:0] mag_w [3];

    logic        [32:0] m4_reg;
    logic        [32:0] mag4_reg [3];
    asft_side_t         side4_reg;
    asft_side_t         side4_next;

    logic        [30:0] quot [3];
    asft_side_t         side_dv_reg [DIV_STAGES];

    logic signed [31:0] c5_reg  [3];
    asft_side_t         side5_reg;
    logic signed [63:0] pr6_reg [3];
    asft_side_t         side6_reg;
    logic signed [34:0] e7_reg  [3];
    asft_side_t         side7_reg;
    logic        [48:0] pl8_reg [3];
    logic signed [48:0] ph8_reg [3];
    asft_side_t         side8_reg;
    logic signed [66:0] pk9_reg [3];
    asft_side_t         side9_reg;
    logic [2:0][31:0]   f10_reg;
    asft_side_t         side10_reg;

    logic [2:0][33:0]   body_arm;
    logic [2:0][31:0]   tq_bond;
    logic [2:0][31:0]   tq_body;
    logic [2:0][31:0]   f_line_reg [3];

    // The whole pipeline moves together unless a finished word is held at the output.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg      <= K_RST;
            r0_reg     <= R0_RST;
            cen_reg[0] <= '0;
            cen_reg[1] <= '0;
            cen_reg[2] <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SPRING: k_reg      <= cfg_wdata[30:0];
                REG_REST:   r0_reg     <= cfg_wdata[30:0];
                REG_CEN_X:  cen_reg[0] <= cfg_wdata;
                REG_CEN_Y:  cen_reg[1] <= cfg_wdata;
                REG_CEN_Z:  cen_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            anc[i]    = s_tdata[32*i +: 32];
            tail[i]   = s_tdata[96 + 32*i +: 32];
            dir_in[i] = s_tdata[192 + 16*i +: 16];
        end
        bond_in = s_tdata[240 +: 31];
    end

    // Separation magnitudes; one shared halving keeps every square in 64 bits.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag1[i] = dr1_reg[i][32] ? (~dr1_reg[i] + 33'd1) : dr1_reg[i];
        end
        shr1 = |{mag1[0][32:31], mag1[1][32:31], mag1[2][32:31]};
        for (int i = 0; i < 3; i++) begin
            d1[i] = shr1 ? mag1[i][32:1] : mag1[i][31:0];
        end
    end

    always_comb begin
        m_w = side_sq_reg[SQ_STAGES-1].shr ? {root_sq, 1'b0} : {1'b0, root_sq};
        for (int i = 0; i < 3; i++) begin
            mag_w[i] = side_sq_reg[SQ_STAGES-1].dr[i][32] ?
                       (~side_sq_reg[SQ_STAGES-1].dr[i] + 33'd1) :
                       side_sq_reg[SQ_STAGES-1].dr[i];
        end
    end

    always_comb begin
        side2_next = '0;
        for (int i = 0; i < 3; i++) begin
            side2_next.dr[i]       = dr1_reg[i];
            side2_next.arm_body[i] = bd1_reg[i];
        end
        side2_next.shr = shr1;

        side3_next = side2_reg;
        for (int i = 0; i < 3; i++) begin
            side3_next.arm_bond[i] = 34'($signed(side2_reg.dr[i]))
                                     - 34'(po2_reg[i] >>> 15);
        end

        side4_next      = side_sq_reg[SQ_STAGES-1];
        side4_next.zero = (m_w == '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                dr1_reg[i]  <= 33'(anc[i]) - 33'(tail[i]);
                bd1_reg[i]  <= 33'(anc[i]) - 33'(cen_reg[i]);
                dir1_reg[i] <= dir_in[i];
            end
            bond1_reg <= bond_in;

            for (int i = 0; i < 3; i++) begin
                sq2_reg[i] <= d1[i] * d1[i];
                po2_reg[i] <= dir1_reg[i] * $signed({1'b0, bond1_reg});
            end
            side2_reg <= side2_next;

            sum3_reg  <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
            side3_reg <= side3_next;

            side_sq_reg[0] <= side3_reg;
            for (int s = 1; s < SQ_STAGES; s++) begin
                side_sq_reg[s] <= side_sq_reg[s-1];
            end

            m4_reg <= m_w;
            for (int i = 0; i < 3; i++) begin
                mag4_reg[i] <= mag_w[i];
            end
            side4_reg <= side4_next;

            side_dv_reg[0] <= side4_reg;
            for (int s = 1; s < DIV_STAGES; s++) begin
                side_dv_reg[s] <= side_dv_reg[s-1];
            end

            for (int i = 0; i < 3; i++) begin
                c5_reg[i] <= side_dv_reg[DIV_STAGES-1].dr[i][32] ?
                             -$signed({1'b0, quot[i]}) : $signed({1'b0, quot[i]});
            end
            side5_reg <= side_dv_reg[DIV_STAGES-1];

            for (int i = 0; i < 3; i++) begin
                pr6_reg[i] <= $signed({1'b0, r0_reg}) * c5_reg[i];
            end
            side6_reg <= side5_reg;

            for (int i = 0; i < 3; i++) begin
                e7_reg[i] <= 35'($signed(side6_reg.dr[i])) - 35'(pr6_reg[i] >>> 30);
            end
            side7_reg <= side6_reg;

            // Stiffness times the 35 bit error is split into two partial products.
            for (int i = 0; i < 3; i++) begin
                pl8_reg[i] <= k_reg * e7_reg[i][17:0];
                ph8_reg[i] <= $signed({1'b0, k_reg}) * $signed(e7_reg[i][34:18]);
            end
            side8_reg <= side7_reg;

            for (int i = 0; i < 3; i++) begin
                pk9_reg[i] <= (67'(ph8_reg[i]) <<< 18) + 67'(pl8_reg[i]);
            end
            side9_reg <= side8_reg;

            for (int i = 0; i < 3; i++) begin
                f10_reg[i] <= side9_reg.zero ? '0 : sat32(67'(pk9_reg[i] >>> FRAC_BITS));
            end
            side10_reg <= side9_reg;

            f_line_reg[0] <= f10_reg;
            f_line_reg[1] <= f_line_reg[0];
            f_line_reg[2] <= f_line_reg[1];
        end
    end

    asft_sqrt u_sqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (sum3_reg),
        .root (root_sq)
    );

    for (genvar i = 0; i < 3; i++) begin : g_div
        asft_div u_div (
            .aclk     (aclk),
            .en       (en),
            .divisor  (m4_reg),
            .rem_init (mag4_reg[i][32:1]),
            .lsb      (mag4_reg[i][0]),
            .quot     (quot[i])
        );
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            body_arm[i] = 34'($signed(side10_reg.arm_body[i]));
        end
    end

    asft_cross #(.FRAC_BITS(FRAC_BITS)) u_cross_bond (
        .aclk   (aclk),
        .en     (en),
        .arm    (side10_reg.arm_bond),
        .frc    (f10_reg),
        .torque (tq_bond)
    );

    asft_cross #(.FRAC_BITS(FRAC_BITS)) u_cross_body (
        .aclk   (aclk),
        .en     (en),
        .arm    (body_arm),
        .frc    (f10_reg),
        .torque (tq_body)
    );

    assign m_tdata = {tq_body, tq_bond, f_line_reg[2]};

`ifndef ASSERT_OFF
    // The root never falls more than one unit short of any separation component.
    a_root_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[V_T4] && !side4_reg.zero |->
            (34'(mag4_reg[0]) <= 34'(m4_reg) + 34'd1) &&
            (34'(mag4_reg[1]) <= 34'(m4_reg) + 34'd1) &&
            (34'(mag4_reg[2]) <= 34'(m4_reg) + 34'd1))
        else $error("separation exceeds computed length");

    // A unit component stays below one and a half.
    a_quot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        en && vld_reg[V_T5-1] && !side_dv_reg[DIV_STAGES-1].zero |->
            (quot[0][30:29] != 2'b11) && (quot[1][30:29] != 2'b11) &&
            (quot[2][30:29] != 2'b11))
        else $error("unit component out of range");

    // Zero separation yields zero force.
    a_zero_force: assert property (@(posedge aclk) disable iff (!aresetn)
        en && vld_reg[V_T9] && side9_reg.zero |=> f10_reg == '0)
        else $error("force not cleared on zero separation");

    // A stall freezes the valid pattern of every stage.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during stall");
`endif

endmodule

[rtl/core/asft_sqrt.sv]
// Pipelined integer square root of a 64 bit value, two root bits per stage.
module asft_sqrt (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] rad,
    output logic [31:0] root
);
    import asft_pkg::*;

    logic [34:0] rem_reg  [SQ_STAGES];
    logic [31:0] root_reg [SQ_STAGES];
    logic [63:0] rad_reg  [SQ_STAGES];

    for (genvar g = 0; g < SQ_STAGES; g++) begin : g_st
        logic [34:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] rad_in;
        logic [34:0] rem_next;
        logic [31:0] root_next;
        logic [63:0] rad_next;

        if (g == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end else begin : g_rest
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
            assign rad_in  = rad_reg[g-1];
        end

        always_comb begin
            logic [34:0] r2;
            logic [34:0] trial;
            rem_next  = rem_in;
            root_next = root_in;
            rad_next  = rad_in;
            r2        = '0;
            trial     = '0;
            for (int k = 0; k < STEPS_PER_STAGE; k++) begin
                if (g * STEPS_PER_STAGE + k < SQ_STEPS) begin
                    r2    = {rem_next[32:0], rad_next[63:62]};
                    trial = {1'b0, root_next, 2'b01};
                    if (r2 >= trial) begin
                        rem_next  = r2 - trial;
                        root_next = {root_next[30:0], 1'b1};
                    end else begin
                        rem_next  = r2;
                        root_next = {root_next[30:0], 1'b0};
                    end
                    rad_next = {rad_next[61:0], 2'b00};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g]  <= rem_next;
                root_reg[g] <= root_next;
                rad_reg[g]  <= rad_next;
            end
        end
    end

    assign root = root_reg[SQ_STAGES-1];

endmodule

[rtl/core/asft_div.sv]
// Pipelined restoring divider: 31 bit quotient of (mag << 30) / divisor.
module asft_div (
    input  logic        aclk,
    input  logic        en,
    input  logic [32:0] divisor,
    input  logic [31:0] rem_init,
    input  logic        lsb,
    output logic [30:0] quot
);
    import asft_pkg::*;

    logic [33:0] rem_reg [DIV_STAGES];
    logic [30:0] q_reg   [DIV_STAGES];
    logic [32:0] d_reg   [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_st
        logic [33:0] rem_in;
        logic [30:0] q_in;
        logic [32:0] d_in;
        logic [33:0] rem_next;
        logic [30:0] q_next;

        if (g == 0) begin : g_first
            assign rem_in = {2'b00, rem_init};
            assign q_in   = '0;
            assign d_in   = divisor;
        end else begin : g_rest
            assign rem_in = rem_reg[g-1];
            assign q_in   = q_reg[g-1];
            assign d_in   = d_reg[g-1];
        end

        // Only the first numerator bit below the initial remainder can be set.
        always_comb begin
            logic [33:0] r2;
            rem_next = rem_in;
            q_next   = q_in;
            r2       = '0;
            for (int k = 0; k < STEPS_PER_STAGE; k++) begin
                if (g * STEPS_PER_STAGE + k < DIV_STEPS) begin
                    r2 = {rem_next[32:0], (g * STEPS_PER_STAGE + k == 0) ? lsb : 1'b0};
                    if (r2 >= {1'b0, d_in}) begin
                        rem_next = r2 - {1'b0, d_in};
                        q_next   = {q_next[29:0], 1'b1};
                    end else begin
                        rem_next = r2;
                        q_next   = {q_next[29:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g] <= rem_next;
                q_reg[g]   <= q_next;
                d_reg[g]   <= d_in;
            end
        end
    end

    assign quot = q_reg[DIV_STAGES-1];

endmodule

[rtl/core/asft_cross.sv]
// Three stage cross product arm x force with fixed point rescale and saturation.
module asft_cross #(
    parameter int FRAC_BITS = asft_pkg::FRAC_BITS_DEF
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [2:0][33:0] arm,
    input  logic [2:0][31:0] frc,
    output logic [2:0][31:0] torque
);
    import asft_pkg::*;

    logic signed [65:0] pa_reg [3];
    logic signed [65:0] pb_reg [3];
    logic signed [66:0] df_reg [3];
    logic        [31:0] tq_reg [3];

    for (genvar i = 0; i < 3; i++) begin : g_ax
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        always_ff @(posedge aclk) begin
            if (en) begin
                pa_reg[i] <= $signed(arm[J]) * $signed(frc[K]);
                pb_reg[i] <= $signed(arm[K]) * $signed(frc[J]);
                df_reg[i] <= 67'(pa_reg[i]) - 67'(pb_reg[i]);
                tq_reg[i] <= sat32(67'(df_reg[i] >>> FRAC_BITS));
            end
        end

        assign torque[i] = tq_reg[i];
    end

endmodule
